FILE: design/lcd_nibble_command_sequencer_core_defines.svh
// Assertion macros for the LCD nibble command sequencer.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef LCD_NIBBLE_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define LCD_NIBBLE_COMMAND_SEQUENCER_CORE_DEFINES_SVH

// The expression holds at every clock edge outside reset.
`define LNS_ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define LNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lncs_pkg.sv
// Types, codes and the power-up command table of the LCD nibble sequencer.
// Used by lcd_nibble_command_sequencer_core; depends on nothing else.
package lncs_pkg;

  localparam int unsigned WAIT_W = 10;

  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_CHAR   = 2'd1;
  localparam logic [1:0] MODE_CURSOR = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] CFG_SHORT  = 2'd0;
  localparam logic [1:0] CFG_MEDIUM = 2'd1;
  localparam logic [1:0] CFG_LONG   = 2'd2;

  localparam logic [3:0] BOOT_LEN = 4'd14;

  localparam logic [3:0] NIB_CURSOR_ROW0 = 4'd8;
  localparam logic [3:0] NIB_CURSOR_ROW1 = 4'd12;
  localparam logic [3:0] NIB_CLEAR_HI    = 4'd0;
  localparam logic [3:0] NIB_CLEAR_LO    = 4'd1;

  typedef struct packed {
    logic       rs;
    logic       long_w;
    logic       medium_w;
    logic       short_w;
    logic [3:0] nibble;
  } entry_t;

  function automatic entry_t power_up_entry(input logic [3:0] idx);
    logic [7:0] raw;
    case (idx)
      4'd0:    raw = 8'h13;
      4'd1:    raw = 8'h13;
      4'd2:    raw = 8'h13;
      4'd3:    raw = 8'h12;
      4'd4:    raw = 8'h02;
      4'd5:    raw = 8'h18;
      4'd6:    raw = 8'h00;
      4'd7:    raw = 8'h1C;
      4'd8:    raw = 8'h00;
      4'd9:    raw = 8'h41;
      4'd10:   raw = 8'h00;
      4'd11:   raw = 8'h16;
      4'd12:   raw = 8'h00;
      4'd13:   raw = 8'h41;
      default: raw = 8'h00;
    endcase
    return entry_t'(raw);
  endfunction

endpackage

FILE: design/lcd_nibble_command_sequencer_core.sv
// LCD nibble command sequencer: queue of nibble entries drained by ticks.
// One item is accepted per cycle unless the output stalls; the registered result
// appears in the cycle after acceptance. The queue is a row memory (two entries
// per row) with a registered read; the head row is prefetched every cycle, with
// write forwarding. Reset is asynchronous; the power-up sequence is served from a
// constant table for the first fourteen pops, so no clearing pass follows reset.
`include "lcd_nibble_command_sequencer_core_defines.svh"

module lcd_nibble_command_sequencer_core #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [7:0]                  char_code_i,
  input  logic [3:0]                  column_i,
  input  logic                        row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [3:0]                  data_nibble_o,
  output logic                        register_select_o,
  output logic                        enable_strobe_o,
  output logic                        waiting_o,
  output logic [5:0]                  queue_level_o,
  output logic                        overflow_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [lncs_pkg::WAIT_W-1:0] cfg_data_i
);
  import lncs_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned ROWS  = QUEUE_DEPTH / 2;
  localparam int unsigned ROW_W = $clog2(ROWS);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST     = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0] ROW_BOOT     = ROW_W'(BOOT_LEN / 2);
  localparam logic [CNT_W-1:0] CNT_BOOT     = CNT_W'(BOOT_LEN);
  localparam logic [CNT_W-1:0] CNT_PUSH_MAX = CNT_W'(QUEUE_DEPTH - 2);
  localparam logic [CNT_W-1:0] CNT_FULL     = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0] SUM_DEPTH    = SUM_W'(QUEUE_DEPTH);

  logic [15:0]       mem [ROWS];
  logic [15:0]       head_row_q;

  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [ROW_W-1:0]  wr_row_q, wr_row_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic [3:0]        boot_q, boot_d;
  logic [WAIT_W-1:0] short_q, medium_q, long_q;

  logic              out_valid_q;
  logic [3:0]        nib_q;
  logic              rs_q, strobe_q, waiting_q, ovf_q;
  logic [5:0]        level_q;

  logic              in_fire, is_tick, booting, full;
  logic              pop, countdown, push, ovf;
  entry_t            head;
  entry_t            push_lo, push_hi;
  logic [15:0]       push_row;
  logic [WAIT_W-1:0] wait_load;
  logic [ROW_W-1:0]  rd_row_addr;
  logic [CNT_W+5:0]  cnt_ext;

  logic [SUM_W-1:0]  idx_sum, idx_wrap, wr_expect;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign is_tick   = (mode_i == MODE_TICK);
  assign booting   = (boot_q != BOOT_LEN);
  assign full      = (cnt_q > CNT_PUSH_MAX);
  assign pop       = in_fire && is_tick && (wait_q == '0) && (cnt_q != '0);
  assign countdown = in_fire && is_tick && (wait_q != '0);
  assign push      = in_fire && !is_tick && !full;
  assign ovf       = in_fire && !is_tick && full;

  always_comb begin
    if (booting) begin
      head = power_up_entry(rd_idx_q[3:0]);
    end else if (rd_idx_q[0]) begin
      head = entry_t'(head_row_q[15:8]);
    end else begin
      head = entry_t'(head_row_q[7:0]);
    end
  end

  always_comb begin
    push_lo = '0;
    push_hi = '0;
    case (mode_i)
      MODE_CHAR: begin
        push_lo.rs       = 1'b1;
        push_lo.nibble   = char_code_i[7:4];
        push_hi.rs       = 1'b1;
        push_hi.medium_w = 1'b1;
        push_hi.nibble   = char_code_i[3:0];
      end
      MODE_CURSOR: begin
        push_lo.nibble  = row_i ? NIB_CURSOR_ROW1 : NIB_CURSOR_ROW0;
        push_hi.short_w = 1'b1;
        push_hi.nibble  = column_i;
      end
      MODE_CLEAR: begin
        push_lo.nibble = NIB_CLEAR_HI;
        push_hi.long_w = 1'b1;
        push_hi.nibble = NIB_CLEAR_LO;
      end
      default: begin
      end
    endcase
  end
  assign push_row = {push_hi, push_lo};

  always_comb begin
    if (head.short_w) begin
      wait_load = short_q;
    end else if (head.medium_w) begin
      wait_load = medium_q;
    end else if (head.long_w) begin
      wait_load = long_q;
    end else begin
      wait_load = '0;
    end
  end

  always_comb begin
    rd_idx_d = rd_idx_q;
    wr_row_d = wr_row_q;
    cnt_d    = cnt_q;
    wait_d   = wait_q;
    boot_d   = boot_q;
    if (pop) begin
      rd_idx_d = (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + 1'b1;
      cnt_d    = cnt_q - 1'b1;
      wait_d   = wait_load;
      if (booting) begin
        boot_d = boot_q + 1'b1;
      end
    end else if (countdown) begin
      wait_d = wait_q - 1'b1;
    end else if (push) begin
      wr_row_d = (wr_row_q == ROW_LAST) ? '0 : wr_row_q + 1'b1;
      cnt_d    = cnt_q + CNT_W'(2);
    end
  end

  assign rd_row_addr = rd_idx_d[IDX_W-1:1];
  assign cnt_ext     = (CNT_W + 6)'(cnt_d);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_row_q] <= push_row;
    end
    if (push && (wr_row_q == rd_row_addr)) begin
      head_row_q <= push_row;
    end else begin
      head_row_q <= mem[rd_row_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      wr_row_q    <= ROW_BOOT;
      cnt_q       <= CNT_BOOT;
      wait_q      <= '0;
      boot_q      <= '0;
      short_q     <= WAIT_W'(5);
      medium_q    <= WAIT_W'(8);
      long_q      <= WAIT_W'(250);
      out_valid_q <= 1'b0;
    end else begin
      rd_idx_q <= rd_idx_d;
      wr_row_q <= wr_row_d;
      cnt_q    <= cnt_d;
      wait_q   <= wait_d;
      boot_q   <= boot_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SHORT:  short_q  <= cfg_data_i;
          CFG_MEDIUM: medium_q <= cfg_data_i;
          CFG_LONG:   long_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      nib_q     <= pop ? head.nibble : 4'd0;
      rs_q      <= pop && head.rs;
      strobe_q  <= pop;
      waiting_q <= (wait_d != '0);
      level_q   <= cnt_ext[5:0];
      ovf_q     <= ovf;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign data_nibble_o     = nib_q;
  assign register_select_o = rs_q;
  assign enable_strobe_o   = strobe_q;
  assign waiting_o         = waiting_q;
  assign queue_level_o     = level_q;
  assign overflow_o        = ovf_q;

  assign idx_sum   = SUM_W'(rd_idx_q) + SUM_W'(cnt_q);
  assign idx_wrap  = (idx_sum >= SUM_DEPTH) ? idx_sum - SUM_DEPTH : idx_sum;
  assign wr_expect = SUM_W'({wr_row_q, 1'b0});

  `LNS_ASSERT_HOLDS(a_count_bound, cnt_q <= CNT_FULL, "Entry count exceeds queue depth.")
  `LNS_ASSERT_HOLDS(a_ring_consistent, idx_wrap == wr_expect, "Ring pointers disagree with count.")
  `LNS_ASSERT_HOLDS(a_boot_bound, boot_q <= BOOT_LEN, "Power-up pop counter overran.")
  `LNS_ASSERT_NEXT(a_push_no_strobe, in_fire && !is_tick, !strobe_q, "Push item strobed a nibble.")
  `LNS_ASSERT_NEXT(a_tick_no_ovf, in_fire && is_tick, !ovf_q, "Tick item flagged overflow.")

endmodule
